[rtl/core/dvps_pkg.sv]
`default_nettype none

package dvps_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DAMP_BITS   = 15;
    localparam int DT_BITS     = 16;
    localparam int TERM_SHIFT  = 2 * DT_BITS + 1;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W + 1;
    localparam int DAMPED_W    = DATA_W + 1 + DAMP_BITS + 2;
    localparam int SUM_W       = PROD_W + 2;
    localparam int NUM_AXES    = 3;
    localparam int AXIS_Y      = 1;
    localparam int ACTION_W    = 3;
    localparam int CFG_INDEX_W = 2;

    localparam longint GRAV_MAG = ((longint'(98) << FRAC_BITS) + 5) / 10;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sh0000_0000_8000_0000);

    localparam logic [ACTION_W-1:0] ACT_PLACE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FORCE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STEP  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PIN   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_UNPIN = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_INV_MASS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAMPING  = 2'd1;

    localparam logic [31:0] INV_MASS_RESET = 32'd65536;
    localparam logic [15:0] DAMPING_RESET  = 16'd32440;

    typedef enum logic [1:0] {
        LOP_NONE,
        LOP_PLACE,
        LOP_FORCE,
        LOP_STEP
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     start;
        logic     mul;
        logic     commit;
    } lane_ctrl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[DATA_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/dvps_lane.sv]
`default_nettype none

module dvps_lane
    import dvps_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lane_ctrl_t               ctrl,
    input  wire logic                     grav_en,
    input  wire logic signed [DATA_W-1:0] vec,
    input  wire logic        [31:0]       inv_mass,
    input  wire logic        [15:0]       damping,
    input  wire logic        [31:0]       dt2,
    output logic signed      [DATA_W-1:0] pos
);

    logic signed [DATA_W-1:0]   cur_reg;
    logic signed [DATA_W-1:0]   prev_reg;
    logic signed [DATA_W-1:0]   acc_reg;
    lane_op_t                   op_reg;

    logic signed [DATA_W-1:0]   vec_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [DAMPED_W-1:0] dv_reg;
    logic signed [DATA_W-1:0]   accg_reg;
    logic signed [PROD_W-1:0]   term_reg;
    logic signed [DATA_W-1:0]   fsum_reg;

    logic signed [DATA_W:0]     vel;
    logic signed [DAMPED_W-1:0] dv_next;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [DATA_W-1:0]   accg_next;
    logic signed [PROD_W-1:0]   term_next;
    logic signed [DATA_W-1:0]   fsum_next;
    logic signed [DATA_W-1:0]   pos_next;
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [DAMPED_W-1:0] dv_sh;
    logic signed [PROD_W-1:0]   term_sh;

    assign vel       = (DATA_W+1)'(cur_reg) - (DATA_W+1)'(prev_reg);
    assign dv_next   = DAMPED_W'(vel) * DAMPED_W'($signed({1'b0, damping}));
    assign prod_next = PROD_W'(vec) * PROD_W'($signed({1'b0, inv_mass}));
    assign accg_next = grav_en ? sat32(SUM_W'(acc_reg) - SUM_W'(GRAV_MAG)) : acc_reg;

    assign term_next = PROD_W'(accg_reg) * PROD_W'($signed({1'b0, dt2}));
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign fsum_next = sat32(SUM_W'(acc_reg) + SUM_W'(prod_sh));

    assign dv_sh     = dv_reg >>> DAMP_BITS;
    assign term_sh   = term_reg >>> TERM_SHIFT;
    assign pos_next  = sat32(SUM_W'(cur_reg) + SUM_W'(dv_sh) + SUM_W'(term_sh));

    assign pos = cur_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            vec_reg  <= vec;
            prod_reg <= prod_next;
            dv_reg   <= dv_next;
            accg_reg <= accg_next;
        end
        if (ctrl.mul)
        begin
            term_reg <= term_next;
            fsum_reg <= fsum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            prev_reg <= '0;
            acc_reg  <= '0;
            op_reg   <= LOP_NONE;
        end
        else
        begin
            if (ctrl.start)
                op_reg <= ctrl.op;
            if (ctrl.commit)
            begin
                case (op_reg)
                    LOP_PLACE:
                    begin
                        cur_reg  <= vec_reg;
                        prev_reg <= vec_reg;
                        acc_reg  <= '0;
                    end
                    LOP_FORCE:
                    begin
                        acc_reg <= fsum_reg;
                    end
                    LOP_STEP:
                    begin
                        prev_reg <= cur_reg;
                        cur_reg  <= pos_next;
                        acc_reg  <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/dvps_merge.sv]
`default_nettype none

module dvps_merge
    import dvps_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire logic signed [DATA_W-1:0] lane_pos [NUM_AXES],
    input  wire logic                     pin,
    input  wire logic                     out_stall,
    output logic                          free,
    output logic                          out_valid,
    output logic signed      [DATA_W-1:0] pos_x,
    output logic signed      [DATA_W-1:0] pos_y,
    output logic signed      [DATA_W-1:0] pos_z,
    output logic                          pinned
);

    logic                     valid_reg;
    logic signed [DATA_W-1:0] pos_reg [NUM_AXES];
    logic                     pin_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign pos_x     = pos_reg[0];
    assign pos_y     = pos_reg[1];
    assign pos_z     = pos_reg[2];
    assign pinned    = pin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load && free)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            pos_reg <= lane_pos;
            pin_reg <= pin;
        end
    end

endmodule

`default_nettype wire

[rtl/core/damped_verlet_particle_step.sv]
// From the accepting edge a word passes the lane start, multiply and commit registers and
// then the output register for out_valid; the three axis lanes run the multiply and
// commit stages in lockstep and the next word enters only after the output register loads.
// Reset: positions, accelerations and pin flag clear to zero; inv_mass resets to 65536,
// damping to 32440; no valid output after reset.
`default_nettype none

module damped_verlet_particle_step
    import dvps_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic        [ACTION_W-1:0] action,
    input  wire logic signed [DATA_W-1:0]  vec_x,
    input  wire logic signed [DATA_W-1:0]  vec_y,
    input  wire logic signed [DATA_W-1:0]  vec_z,
    input  wire logic        [15:0]        time_step,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed      [DATA_W-1:0]  pos_x,
    output logic signed      [DATA_W-1:0]  pos_y,
    output logic signed      [DATA_W-1:0]  pos_z,
    output logic                           pinned,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic     [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic        [31:0]        cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMMIT,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic        [31:0]       inv_mass_reg;
    logic        [15:0]       damping_reg;
    logic                     pin_reg;
    logic                     pin_next;
    logic        [31:0]       dt2_reg;
    logic                     accept;
    logic                     free;
    lane_op_t                 op;
    lane_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] vec      [NUM_AXES];
    logic signed [DATA_W-1:0] lane_pos [NUM_AXES];

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign vec[0] = vec_x;
    assign vec[1] = vec_y;
    assign vec[2] = vec_z;

    always_comb
    begin
        op       = LOP_NONE;
        pin_next = pin_reg;
        case (action)
            ACT_PLACE: op = LOP_PLACE;
            ACT_FORCE: op = LOP_FORCE;
            ACT_STEP:  op = pin_reg ? LOP_NONE : LOP_STEP;
            ACT_PIN:   pin_next = 1'b1;
            ACT_UNPIN: pin_next = 1'b0;
            default:   op = LOP_NONE;
        endcase
    end

    assign ctrl.op     = op;
    assign ctrl.start  = accept;
    assign ctrl.mul    = (state_reg == ST_MUL);
    assign ctrl.commit = (state_reg == ST_COMMIT);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_MUL;
            ST_MUL:    state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_OUT;
            ST_OUT:    if (free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pin_reg      <= 1'b0;
            inv_mass_reg <= INV_MASS_RESET;
            damping_reg  <= DAMPING_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                pin_reg <= pin_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INV_MASS: inv_mass_reg <= cfg_data;
                    CFG_DAMPING:  damping_reg  <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            dt2_reg <= 32'(time_step) * 32'(time_step);
    end

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        dvps_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .grav_en  (g == AXIS_Y),
            .vec      (vec[g]),
            .inv_mass (inv_mass_reg),
            .damping  (damping_reg),
            .dt2      (dt2_reg),
            .pos      (lane_pos[g])
        );
    end

    dvps_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (state_reg == ST_OUT),
        .lane_pos  (lane_pos),
        .pin       (pin_reg),
        .out_stall (out_stall),
        .free      (free),
        .out_valid (out_valid),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .pinned    (pinned)
    );

endmodule

`default_nettype wire

[verif/damped_verlet_particle_step_tb.sv]
`default_nettype none

module damped_verlet_particle_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dvps_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic                     pin;
    } particle_word_t;

    localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD_C = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic signed [DATA_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] POS_MIN = 32'sh8000_0000;
    localparam longint S32_TOP    = 64'sd2147483647;
    localparam longint S32_BOTTOM = -64'sd2147483647 - 64'sd1;
    localparam longint GRAVITY_Q  = ((longint'(98) << FRAC_BITS) + 5) / 10;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [ACTION_W-1:0]        action;
    logic signed [DATA_W-1:0]   vec_x;
    logic signed [DATA_W-1:0]   vec_y;
    logic signed [DATA_W-1:0]   vec_z;
    logic [15:0]                time_step;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [DATA_W-1:0]   pos_x;
    logic signed [DATA_W-1:0]   pos_y;
    logic signed [DATA_W-1:0]   pos_z;
    logic                       pinned;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [31:0]                cfg_data;

    int          cur_pos [3];
    int          last_pos [3];
    int          accel_acc [3];
    bit          pin_state;
    logic [31:0] inv_mass_q;
    logic [15:0] damp_q;

    particle_word_t pending_results [$];

    bit rx_idle_en;
    bit tx_gap_en;
    int hold_left;
    int burst_left;
    int cycle_count;
    int mismatch_count;
    int results_checked;
    int cfg_writes;
    int act_count [8];

    damped_verlet_particle_step DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int clamp_s32(input longint v);
        if (v > S32_TOP)
            return int'(S32_TOP);
        if (v < S32_BOTTOM)
            return int'(S32_BOTTOM);
        return int'(v);
    endfunction

    function automatic particle_word_t advance_particle(
        input logic [ACTION_W-1:0]      act,
        input logic signed [DATA_W-1:0] vx,
        input logic signed [DATA_W-1:0] vy,
        input logic signed [DATA_W-1:0] vz,
        input logic [15:0]              dt
    );
        longint         v [3];
        longint         dt_sq;
        longint         vel;
        longint         damped;
        longint         term;
        int             nxt;
        particle_word_t r;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        dt_sq = longint'(dt) * longint'(dt);
        case (act)
            ACT_PLACE:
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    cur_pos[i] = int'(v[i]);
                    last_pos[i] = int'(v[i]);
                    accel_acc[i] = 0;
                end
            end
            ACT_FORCE:
            begin
                for (int i = 0; i < NUM_AXES; i++)
                    accel_acc[i] = clamp_s32(longint'(accel_acc[i])
                        + ((v[i] * longint'(inv_mass_q)) >>> FRAC_BITS));
            end
            ACT_STEP:
            begin
                if (!pin_state)
                begin
                    accel_acc[AXIS_Y] = clamp_s32(longint'(accel_acc[AXIS_Y]) - GRAVITY_Q);
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        vel = longint'(cur_pos[i]) - longint'(last_pos[i]);
                        damped = (vel * longint'(damp_q)) >>> DAMP_BITS;
                        term = (longint'(accel_acc[i]) * dt_sq) >>> TERM_SHIFT;
                        nxt = clamp_s32(longint'(cur_pos[i]) + damped + term);
                        last_pos[i] = cur_pos[i];
                        cur_pos[i] = nxt;
                        accel_acc[i] = 0;
                    end
                end
            end
            ACT_PIN:   pin_state = 1'b1;
            ACT_UNPIN: pin_state = 1'b0;
            default:   ;
        endcase
        r.x = cur_pos[0];
        r.y = cur_pos[1];
        r.z = cur_pos[2];
        r.pin = pin_state;
        return r;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endfunction

    always @(posedge clk)
    begin
        particle_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected word: pos %0d %0d %0d pinned %0b",
                    pos_x, pos_y, pos_z, pinned));
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (pos_x !== want.x)
                    note_mismatch($sformatf("word %0d pos_x: expected %0d, got %0d",
                        results_checked, want.x, pos_x));
                if (pos_y !== want.y)
                    note_mismatch($sformatf("word %0d pos_y: expected %0d, got %0d",
                        results_checked, want.y, pos_y));
                if (pos_z !== want.z)
                    note_mismatch($sformatf("word %0d pos_z: expected %0d, got %0d",
                        results_checked, want.z, pos_z));
                if (pinned !== want.pin)
                    note_mismatch($sformatf("word %0d pinned: expected %0b, got %0b",
                        results_checked, want.pin, pinned));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            out_stall <= 1'b1;
        end
        else if (rx_idle_en && $urandom_range(0, 5) == 0)
        begin
            burst_left = $urandom_range(0, 9);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_word(
        input logic [ACTION_W-1:0]      act,
        input logic signed [DATA_W-1:0] vx,
        input logic signed [DATA_W-1:0] vy,
        input logic signed [DATA_W-1:0] vz,
        input logic [15:0]              dt
    );
        int gap;
        gap = 0;
        if (tx_gap_en && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        vec_x <= vx;
        vec_y <= vy;
        vec_z <= vz;
        time_step <= dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(advance_particle(act, vx, vy, vz, dt));
        act_count[act]++;
    endtask

    task automatic wait_drain();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            note_mismatch($sformatf("%0d expected words never arrived",
                pending_results.size()));
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_INV_MASS: inv_mass_q = data;
            CFG_DAMPING:  damp_q = data[15:0];
            default:      ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_vec();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return POS_MAX;
                    1:       return POS_MIN;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1, 2:    return 16'($urandom);
            default: return 16'($urandom_range(256, 4096));
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return ACT_PLACE;
        if (r < 40)
            return ACT_FORCE;
        if (r < 78)
            return ACT_STEP;
        if (r < 84)
            return ACT_PIN;
        if (r < 94)
            return ACT_UNPIN;
        case ($urandom_range(0, 2))
            0:       return ACT_RSVD_A;
            1:       return ACT_RSVD_B;
            default: return ACT_RSVD_C;
        endcase
    endfunction

    task automatic send_random_word();
        send_word(pick_action(), pick_vec(), pick_vec(), pick_vec(), pick_dt());
    endtask

    task automatic test_directed_corners();
        send_word(ACT_STEP, pick_vec(), pick_vec(), pick_vec(), 16'h0000);
        send_word(ACT_STEP, pick_vec(), pick_vec(), pick_vec(), 16'hFFFF);
        send_word(ACT_STEP, pick_vec(), pick_vec(), pick_vec(), 16'hFFFF);
        send_word(ACT_PLACE, POS_MAX, POS_MIN, 32'sd0, 16'h1234);
        send_word(ACT_FORCE, POS_MAX, POS_MIN, POS_MAX, 16'h0000);
        send_word(ACT_FORCE, POS_MAX, POS_MIN, POS_MAX, 16'hFFFF);
        send_word(ACT_STEP, pick_vec(), pick_vec(), pick_vec(), 16'hFFFF);
        send_word(ACT_STEP, pick_vec(), pick_vec(), pick_vec(), 16'hFFFF);
        send_word(ACT_PLACE, POS_MIN, POS_MAX, -32'sd1, 16'h0001);
        send_word(ACT_FORCE, -32'sd1, -32'sd3, 32'sh0001_0001, 16'h0000);
        send_word(ACT_STEP, pick_vec(), pick_vec(), pick_vec(), 16'h0444);
        send_word(ACT_STEP, pick_vec(), pick_vec(), pick_vec(), 16'h0001);
        send_word(ACT_PIN, pick_vec(), pick_vec(), pick_vec(), pick_dt());
        send_word(ACT_FORCE, 32'sh0002_0000, -32'sh0003_0000, 32'sh0000_8000, 16'h0000);
        send_word(ACT_STEP, pick_vec(), pick_vec(), pick_vec(), 16'hFFFF);
        send_word(ACT_UNPIN, pick_vec(), pick_vec(), pick_vec(), pick_dt());
        send_word(ACT_STEP, pick_vec(), pick_vec(), pick_vec(), 16'h8000);
        send_word(ACT_PIN, pick_vec(), pick_vec(), pick_vec(), pick_dt());
        send_word(ACT_PLACE, 32'sh0010_0000, -32'sh0020_0000, 32'sh0000_0001, 16'h0100);
        send_word(ACT_STEP, pick_vec(), pick_vec(), pick_vec(), 16'h4000);
        send_word(ACT_UNPIN, pick_vec(), pick_vec(), pick_vec(), pick_dt());
        send_word(ACT_RSVD_A, pick_vec(), pick_vec(), pick_vec(), pick_dt());
        send_word(ACT_RSVD_B, pick_vec(), pick_vec(), pick_vec(), pick_dt());
        send_word(ACT_RSVD_C, pick_vec(), pick_vec(), pick_vec(), pick_dt());
        wait_drain();
    endtask

    task automatic test_register_settings();
        logic [31:0] inv_list [5] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                      32'h0001_8000, 32'h0000_3001};
        logic [31:0] damp_list [5] = '{32'h0000_0000, 32'h0000_8000, 32'h0000_FFFF,
                                       32'h0000_4000, 32'hA5A5_7FFF};
        for (int k = 0; k < 5; k++)
        begin
            wait_drain();
            write_cfg(CFG_INV_MASS, inv_list[k]);
            write_cfg(CFG_DAMPING, damp_list[k]);
            repeat (40) send_random_word();
        end
        wait_drain();
        write_cfg(CFG_SPARE_A, $urandom);
        write_cfg(CFG_SPARE_B, $urandom);
        repeat (20) send_random_word();
        wait_drain();
        write_cfg(CFG_INV_MASS, INV_MASS_RESET);
        write_cfg(CFG_DAMPING, {16'h0000, DAMPING_RESET});
    endtask

    task automatic test_full_backpressure();
        rx_idle_en = 1'b0;
        tx_gap_en = 1'b0;
        wait_drain();
        hold_left = 150;
        repeat (16) send_random_word();
        wait_drain();
        rx_idle_en = 1'b1;
        tx_gap_en = 1'b1;
    endtask

    task automatic test_pause_and_resume();
        repeat (20) send_random_word();
        wait_drain();
        repeat (20) send_random_word();
        wait_drain();
    endtask

    task automatic test_random_traffic(input int per_segment);
        for (int seg = 0; seg < 4; seg++)
        begin
            wait_drain();
            write_cfg(CFG_INV_MASS, $urandom_range(0, 1) ? $urandom
                                                        : $urandom_range(32'h1000, 32'h40000));
            write_cfg(CFG_DAMPING, $urandom_range(0, 3) == 0 ? $urandom_range(0, 32768)
                                                             : $urandom_range(30000, 32768));
            repeat (per_segment) send_random_word();
        end
        wait_drain();
    endtask

    task automatic test_steady_stream(input int count);
        rx_idle_en = 1'b0;
        tx_gap_en = 1'b0;
        write_cfg(CFG_INV_MASS, INV_MASS_RESET);
        write_cfg(CFG_DAMPING, {16'h0000, DAMPING_RESET});
        repeat (count) send_random_word();
        wait_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_PLACE;
        vec_x = '0;
        vec_y = '0;
        vec_z = '0;
        time_step = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_INV_MASS;
        cfg_data = '0;
        rx_idle_en = 1'b0;
        tx_gap_en = 1'b0;
        hold_left = 0;
        burst_left = 0;
        mismatch_count = 0;
        results_checked = 0;
        cfg_writes = 0;
        for (int i = 0; i < 8; i++)
            act_count[i] = 0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            cur_pos[i] = 0;
            last_pos[i] = 0;
            accel_acc[i] = 0;
        end
        pin_state = 1'b0;
        inv_mass_q = INV_MASS_RESET;
        damp_q = DAMPING_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        rx_idle_en = 1'b1;
        tx_gap_en = 1'b1;
        test_directed_corners();
        test_register_settings();
        test_full_backpressure();
        test_pause_and_resume();
        test_random_traffic(310);
        test_steady_stream(200);

        $display("Sent %0d words: place %0d, force %0d, step %0d, pin %0d, unpin %0d, unused %0d",
            act_count[0] + act_count[1] + act_count[2] + act_count[3] + act_count[4]
                + act_count[5] + act_count[6] + act_count[7],
            act_count[ACT_PLACE], act_count[ACT_FORCE], act_count[ACT_STEP],
            act_count[ACT_PIN], act_count[ACT_UNPIN],
            act_count[ACT_RSVD_A] + act_count[ACT_RSVD_B] + act_count[ACT_RSVD_C]);
        $display("Register writes %0d, results checked %0d, mismatches %0d",
            cfg_writes, results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
